// ===== sv/lwcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwcd_pkg
// Shared types and constants of the LRU write-back cluster directory.
// ----------------------------------------------------------------------------
package lwcd_pkg;

  localparam int CLUSTER_W = 32;
  localparam int CAP_W     = 5;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'd0;

  typedef logic [1:0] req_kind_t;

  localparam req_kind_t REQ_READ  = 2'd0;
  localparam req_kind_t REQ_WRITE = 2'd1;
  localparam req_kind_t REQ_ZERO  = 2'd2;
  localparam req_kind_t REQ_FLUSH = 2'd3;

  typedef struct packed {
    logic hit;
    logic fill_needed;
    logic writeback_valid;
  } res_flags_t;

endpackage

// ===== sv/lwcd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwcd_cfg
// APB-style register block holding the capacity register.
// ----------------------------------------------------------------------------
module lwcd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lwcd_pkg::ADDR_W-1:0]   paddr,
  input  logic [lwcd_pkg::DATA_W-1:0]   pwdata,
  output logic [lwcd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [lwcd_pkg::CAP_W-1:0]    capacity
);
  import lwcd_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_en && reg_idx == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAPACITY: prdata = DATA_W'(capacity);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== sv/lwcd_dir.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwcd_dir
// Tag store, dirty bits and LRU ranks with the single-pass lookup and update.
// ----------------------------------------------------------------------------
module lwcd_dir #(
  parameter int SLOTS        = 16,
  parameter int CLUSTER_BITS = 32,
  parameter int SLOT_W       = $clog2(SLOTS)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  lwcd_pkg::req_kind_t            kind,
  input  logic [lwcd_pkg::CLUSTER_W-1:0] cluster,
  input  logic [lwcd_pkg::CAP_W-1:0]     capacity,
  output lwcd_pkg::res_flags_t           flags,
  output logic [SLOT_W-1:0]              slot,
  output logic [lwcd_pkg::CLUSTER_W-1:0] wb_cluster,
  output logic [SLOT_W-1:0]              wb_slot
);
  import lwcd_pkg::*;

  localparam int AGE_W = SLOT_W;
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [CLUSTER_BITS-1:0] tag_mem [SLOTS];
  logic [SLOTS-1:0]        valid;
  logic [SLOTS-1:0]        dirty;
  logic [AGE_W-1:0]        age [SLOTS];
  logic [CNT_W-1:0]        used_count;

  logic [SLOTS-1:0]        valid_next;
  logic [SLOTS-1:0]        dirty_next;
  logic [AGE_W-1:0]        age_next [SLOTS];
  logic [CNT_W-1:0]        used_count_next;

  logic [CLUSTER_BITS-1:0] tag;
  logic [SLOTS-1:0]        match;
  logic [SLOTS-1:0]        victim;
  logic [SLOT_W-1:0]       hit_idx;
  logic [SLOT_W-1:0]       free_idx;
  logic [SLOT_W-1:0]       victim_idx;
  logic                    found;
  logic [CNT_W-1:0]        eff_cap;
  logic                    room;
  logic [AGE_W-1:0]        last_rank;
  logic [AGE_W-1:0]        limit;
  logic                    promote;
  logic                    promote_all;
  logic                    tag_we;

  assign tag       = CLUSTER_BITS'(cluster);
  assign last_rank = AGE_W'(used_count - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i]  = valid[i] && tag_mem[i] == tag;
      victim[i] = valid[i] && age[i] == last_rank;
    end
  end

  // lowest index wins in every search
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i])  hit_idx    = SLOT_W'(i);
      if (!valid[i]) free_idx   = SLOT_W'(i);
      if (victim[i]) victim_idx = SLOT_W'(i);
    end
  end

  assign found = |match;
  assign limit = age[hit_idx];

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(capacity) > SLOTS) begin
      eff_cap = CNT_W'(SLOTS);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  assign room = used_count < eff_cap;

  always_comb begin
    flags           = '0;
    slot            = '0;
    wb_cluster      = '0;
    wb_slot         = '0;
    valid_next      = valid;
    dirty_next      = dirty;
    age_next        = age;
    used_count_next = used_count;
    promote         = 1'b0;
    promote_all     = 1'b0;
    tag_we          = 1'b0;
    case (kind)
      REQ_FLUSH: begin
        if (found) begin
          flags.hit = 1'b1;
          slot      = hit_idx;
          if (dirty[hit_idx]) begin
            flags.writeback_valid = 1'b1;
            wb_cluster            = CLUSTER_W'(tag_mem[hit_idx]);
            wb_slot               = hit_idx;
            dirty_next[hit_idx]   = 1'b0;
          end
        end
      end
      default: begin
        if (found) begin
          flags.hit = 1'b1;
          slot      = hit_idx;
          promote   = 1'b1;
          if (kind != REQ_READ) dirty_next[hit_idx] = 1'b1;
        end else begin
          flags.fill_needed = 1'b1;
          if (room) begin
            slot            = free_idx;
            used_count_next = used_count + CNT_W'(1);
          end else begin
            slot = victim_idx;
            if (dirty[victim_idx]) begin
              flags.writeback_valid = 1'b1;
              wb_cluster            = CLUSTER_W'(tag_mem[victim_idx]);
              wb_slot               = victim_idx;
            end
          end
          promote          = 1'b1;
          promote_all      = 1'b1;
          tag_we           = 1'b1;
          valid_next[slot] = 1'b1;
          dirty_next[slot] = kind != REQ_READ;
        end
      end
    endcase
    if (promote) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (SLOT_W'(i) != slot && valid[i] && (promote_all || age[i] < limit)) begin
          age_next[i] = age[i] + AGE_W'(1);
        end
      end
      age_next[slot] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      dirty      <= '0;
      used_count <= '0;
      for (int i = 0; i < SLOTS; i++) age[i] <= '0;
    end else if (fire) begin
      valid      <= valid_next;
      dirty      <= dirty_next;
      used_count <= used_count_next;
      age        <= age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && tag_we) begin
      tag_mem[slot] <= tag;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used_count))
    else $error("used count out of step with valid slots");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("cluster resident in more than one slot");

endmodule

// ===== sv/lru_writeback_cluster_directory.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_writeback_cluster_directory
// Fully associative write-back cluster cache directory with LRU replacement.
// ----------------------------------------------------------------------------
// One item per clock is sustained while the result side does not stall. An
// accepted item is held in the input register and looked up against every
// slot tag in parallel; its result is loaded into the result register at the
// same edge that updates the tags, dirty bits and LRU ranks. The next item is
// looked up against the updated state; throughput is set by that single
// lookup-and-update pass. Capacity writes take effect from the next item
// onwards.
module lru_writeback_cluster_directory #(
  parameter int SLOTS        = 16,
  parameter int CLUSTER_BITS = 32,
  localparam int SLOT_W      = $clog2(SLOTS)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lwcd_pkg::ADDR_W-1:0]    paddr,
  input  logic [lwcd_pkg::DATA_W-1:0]    pwdata,
  output logic [lwcd_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lwcd_pkg::req_kind_t            req_type,
  input  logic [lwcd_pkg::CLUSTER_W-1:0] cluster,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           hit,
  output logic [SLOT_W-1:0]              slot,
  output logic                           fill_needed,
  output logic                           writeback_valid,
  output logic [lwcd_pkg::CLUSTER_W-1:0] writeback_cluster,
  output logic [SLOT_W-1:0]              writeback_slot
);
  import lwcd_pkg::*;

  logic [CAP_W-1:0]     capacity;
  logic                 in_full;
  req_kind_t            in_kind;
  logic [CLUSTER_W-1:0] in_cluster;
  logic                 fire;
  logic                 accept;

  res_flags_t           dir_flags;
  logic [SLOT_W-1:0]    dir_slot;
  logic [CLUSTER_W-1:0] dir_wb_cluster;
  logic [SLOT_W-1:0]    dir_wb_slot;
  res_flags_t           res_flags;

  lwcd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  assign fire      = in_full && (!res_valid || !res_stall);
  assign req_stall = in_full && !fire;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind    <= req_type;
      in_cluster <= cluster;
    end
  end

  lwcd_dir #(
    .SLOTS        (SLOTS),
    .CLUSTER_BITS (CLUSTER_BITS),
    .SLOT_W       (SLOT_W)
  ) u_dir (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .kind       (in_kind),
    .cluster    (in_cluster),
    .capacity   (capacity),
    .flags      (dir_flags),
    .slot       (dir_slot),
    .wb_cluster (dir_wb_cluster),
    .wb_slot    (dir_wb_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_flags         <= dir_flags;
      slot              <= dir_slot;
      writeback_cluster <= dir_wb_cluster;
      writeback_slot    <= dir_wb_slot;
    end
  end

  assign hit             = res_flags.hit;
  assign fill_needed     = res_flags.fill_needed;
  assign writeback_valid = res_flags.writeback_valid;

  a_fire_gives_item: assert property (@(posedge clk) disable iff (rst)
    fire |=> res_valid)
    else $error("processed item did not reach the result register");

  a_hit_or_fill: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(hit && fill_needed))
    else $error("hit and fill both set");

  a_wb_same_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && writeback_valid |-> writeback_slot == slot)
    else $error("write-back slot differs from item slot");

  a_wb_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !writeback_valid |-> writeback_cluster == '0 && writeback_slot == '0)
    else $error("write-back fields set without write-back");

endmodule

// ===== bench/lru_writeback_cluster_directory_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_writeback_cluster_directory_tb
// Self-checking bench for the LRU write-back cluster directory: reads, writes,
// zero fills and flushes over small cluster pools so that hits, evictions and
// write-backs are frequent, under several capacities written over the APB
// port, with random gaps on the request side and random stalls on the result
// side. A scoreboard class tracks tags, dirty bits and LRU ranks and checks
// every result in order.
// ----------------------------------------------------------------------------
module lru_writeback_cluster_directory_tb;
  import lwcd_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                 hit;
    logic [3:0]           slot;
    logic                 fill;
    logic                 wb_valid;
    logic [CLUSTER_W-1:0] wb_cluster;
    logic [3:0]           wb_slot;
  } lookup_t;

  class cluster_dir_scoreboard;
    logic [CLUSTER_W-1:0] tag [SLOTS];
    bit                   present [SLOTS];
    bit                   dirty [SLOTS];
    logic [3:0]           rank [SLOTS];
    int                   used;
    logic [CAP_W-1:0]     capacity;
    lookup_t              pending_lookups [$];
    int                   errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        tag[i] = '0;
        present[i] = 1'b0;
        dirty[i] = 1'b0;
        rank[i] = '0;
      end
      used = 0;
      capacity = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [DATA_W-1:0] value);
      capacity = value[CAP_W-1:0];
    endfunction

    // make slot s most recent, ageing every valid slot younger than lim
    function void promote(int s, int lim);
      for (int i = 0; i < SLOTS; i++) begin
        if (i != s && present[i] && int'(rank[i]) < lim) rank[i] = rank[i] + 4'd1;
      end
      rank[s] = '0;
    endfunction

    function void note_access(req_kind_t kind, logic [CLUSTER_W-1:0] cl);
      lookup_t r;
      int      s;
      bit      found;
      int      oldest;
      int      room;
      r = '0;
      s = 0;
      found = 1'b0;
      room = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && present[i] && tag[i] == cl) begin
          s = i;
          found = 1'b1;
        end
      end
      if (kind == REQ_FLUSH) begin
        if (found) begin
          r.hit = 1'b1;
          r.slot = 4'(s);
          if (dirty[s]) begin
            r.wb_valid = 1'b1;
            r.wb_cluster = tag[s];
            r.wb_slot = 4'(s);
            dirty[s] = 1'b0;
          end
        end
      end else if (found) begin
        r.hit = 1'b1;
        r.slot = 4'(s);
        promote(s, int'(rank[s]));
        if (kind != REQ_READ) dirty[s] = 1'b1;
      end else begin
        r.fill = 1'b1;
        if (used < room) begin
          found = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !present[i]) begin
              s = i;
              found = 1'b1;
            end
          end
          used++;
        end else begin
          oldest = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (present[i] && int'(rank[i]) > oldest) begin
              oldest = int'(rank[i]);
              s = i;
            end
          end
          if (dirty[s]) begin
            r.wb_valid = 1'b1;
            r.wb_cluster = tag[s];
            r.wb_slot = 4'(s);
          end
          present[s] = 1'b0;
        end
        present[s] = 1'b1;
        tag[s] = cl;
        dirty[s] = (kind != REQ_READ);
        promote(s, SLOTS + 1);
        r.slot = 4'(s);
      end
      pending_lookups.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_lookup(lookup_t got);
      lookup_t want;
      if (pending_lookups.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %h", $time, got);
        return;
      end
      want = pending_lookups.pop_front();
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("fill_needed", 32'(want.fill), 32'(got.fill));
      compare_field("writeback_valid", 32'(want.wb_valid), 32'(got.wb_valid));
      compare_field("writeback_cluster", want.wb_cluster, got.wb_cluster);
      compare_field("writeback_slot", 32'(want.wb_slot), 32'(got.wb_slot));
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_kind_t            req_type = REQ_READ;
  logic [CLUSTER_W-1:0] cluster = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b1;
  logic                 hit;
  logic [3:0]           slot;
  logic                 fill_needed;
  logic                 writeback_valid;
  logic [CLUSTER_W-1:0] writeback_cluster;
  logic [3:0]           writeback_slot;

  cluster_dir_scoreboard directory = new();
  bit                    steady = 1'b0;
  int                    cycles = 0;
  logic [CLUSTER_W-1:0]  pool [$];

  lru_writeback_cluster_directory DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .cluster(cluster),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .hit(hit),
    .slot(slot),
    .fill_needed(fill_needed),
    .writeback_valid(writeback_valid),
    .writeback_cluster(writeback_cluster),
    .writeback_slot(writeback_slot)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lru_writeback_cluster_directory: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) directory.note_access(req_type, cluster);
      if (res_valid && !res_stall) begin
        directory.check_lookup(lookup_t'({hit, slot, fill_needed, writeback_valid,
                                          writeback_cluster, writeback_slot}));
      end
    end
  end

  // result side: random stall before each item
  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  task automatic send_access(req_kind_t kind, logic [CLUSTER_W-1:0] cl);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type <= kind;
    cluster <= cl;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic drain_lookups();
    req_valid <= 1'b0;
    @(posedge clk);
    while (directory.pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [DATA_W-1:0] value);
    drain_lookups();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    directory.set_capacity(value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [CLUSTER_W-1:0] pick_cluster();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  initial begin : stimulus
    logic [DATA_W-1:0] cap_plan [12];
    int                pool_size;
    cap_plan = '{32'd31, 32'd17, 32'd16, 32'd1, 32'd0, 32'd2,
                 32'd8, 32'd15, 32'd3, $urandom(), $urandom(), 32'hFFFF_FFF0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity: absent flush, hits, dirty and clean flushes
    send_access(REQ_FLUSH, 32'h0000_0000);
    send_access(REQ_READ, 32'h0000_0000);
    send_access(REQ_READ, 32'h0000_0000);
    send_access(REQ_WRITE, 32'hFFFF_FFFF);
    send_access(REQ_ZERO, 32'h8000_0000);
    send_access(REQ_FLUSH, 32'hFFFF_FFFF);
    send_access(REQ_FLUSH, 32'hFFFF_FFFF);
    send_access(REQ_WRITE, 32'h0000_0000);
    send_access(REQ_READ, 32'h0000_0001);
    send_access(REQ_WRITE, 32'h0000_0002);
    // capacity lowered below the number of resident entries
    write_capacity(32'd2);
    send_access(REQ_READ, 32'h0000_0003);
    send_access(REQ_WRITE, 32'h0000_0004);
    send_access(REQ_READ, 32'h0000_0000);
    send_access(REQ_READ, 32'h0000_0005);
    // capacity of one: every miss replaces the least recently used resident entry
    write_capacity(32'd1);
    send_access(REQ_WRITE, 32'h0000_0006);
    send_access(REQ_WRITE, 32'h0000_0007);
    send_access(REQ_FLUSH, 32'h0000_0007);
    send_access(REQ_READ, 32'h0000_0006);
    send_access(REQ_ZERO, 32'h0000_0000);
    write_capacity(32'd0);
    send_access(REQ_WRITE, 32'h0000_0008);
    send_access(REQ_READ, 32'h0000_0009);

    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      pool.delete();
      pool_size = $urandom_range(2, 22);
      for (int i = 0; i < pool_size; i++) begin
        case ($urandom_range(0, 7))
          0: pool.push_back(32'h0000_0000);
          1: pool.push_back(32'hFFFF_FFFF);
          2: pool.push_back($urandom_range(0, 31));
          default: pool.push_back($urandom());
        endcase
      end
      for (int n = 0; n < 135; n++) begin
        if (n % 30 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) == 0) drain_lookups();
        send_access(req_kind_t'($urandom_range(0, 3)), pick_cluster());
      end
    end

    steady = 1'b0;
    drain_lookups();
    repeat (20) @(posedge clk);
    if (directory.errors == 0 && directory.pending_lookups.size() == 0) begin
      $display("lru_writeback_cluster_directory: match");
    end else begin
      $display("lru_writeback_cluster_directory: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lwcd_pkg.sv
sv/lwcd_cfg.sv
sv/lwcd_dir.sv
sv/lru_writeback_cluster_directory.sv
bench/lru_writeback_cluster_directory_tb.sv
